FILE: hdl/yaw_rate_limited_heading_tracker_macros.svh
// ----------------------------------------------------------------------------
// yaw rate limited heading tracker: assertion macros
// shared property forms used by yrlht_back, clocked on clk with
// rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef YAW_RATE_LIMITED_HEADING_TRACKER_MACROS_SVH
`define YAW_RATE_LIMITED_HEADING_TRACKER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define YRLHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define YRLHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/yrlht_pkg.sv
// ----------------------------------------------------------------------------
// yrlht_pkg
// types, constants and table functions shared by the heading tracker
// ----------------------------------------------------------------------------
package yrlht_pkg;

  // cordic angle resolution and iteration count
  localparam int ANGLE_BITS        = 16;
  localparam int CORDIC_ITERATIONS = 14;
  localparam int ATAN_LEN          = 22;
  localparam int CORDIC_STEPS      =
    (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int ITER_W            = $clog2(CORDIC_STEPS);
  localparam int ATAN_SHIFT        = 32 - ANGLE_BITS;

  // vector datapath: 16 bit input scaled by 4096, plus sign and cordic growth
  localparam int VEL_W   = 16;
  localparam int PRESCL  = 12;
  localparam int XY_W    = VEL_W + PRESCL + 3;

  // rate datapath
  localparam int RATE_W  = 24;
  localparam int PROD_W  = 27;
  localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_MAX_YAW_RATE     = 2'd0;
  localparam logic [1:0] REG_MAX_STEP_CHANGE  = 2'd1;
  localparam logic [1:0] REG_STEPS_PER_SECOND = 2'd2;
  localparam logic [1:0] REG_SPEED_THRESHOLD  = 2'd3;

  localparam logic [22:0] RST_MAX_YAW_RATE     = 23'd65536;
  localparam logic [14:0] RST_MAX_STEP_CHANGE  = 15'd1024;
  localparam logic [9:0]  RST_STEPS_PER_SECOND = 10'd10;
  localparam logic [15:0] RST_SPEED_THRESHOLD  = 16'd26;

  localparam logic OPC_STEP = 1'b0;
  localparam logic OPC_SEED = 1'b1;

  typedef enum logic [1:0] {
    KIND_STEP,
    KIND_HOLD,
    KIND_SEED
  } kind_t;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] seed_yaw;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [23:0] yaw_rate;
    logic               rate_limited;
  } out_item_t;

  typedef struct packed {
    logic [22:0] max_yaw_rate;
    logic [14:0] max_step_change;
    logic [9:0]  steps_per_second;
    logic [15:0] speed_threshold;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] seed_yaw;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-i) in units of 2^-32 of a turn
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146
  };

  // table entry rounded to the cordic angle width
  function automatic logic [ANGLE_BITS-1:0] atan_angle(input logic [4:0] idx);
    logic [4:0]  sel;
    logic [32:0] sum;
    sel = (idx > 5'(ATAN_LEN - 1)) ? 5'(ATAN_LEN - 1) : idx;
    sum = {1'b0, ATAN_TAB[sel]} + (33'd1 << (ATAN_SHIFT - 1));
    return sum[ATAN_SHIFT +: ANGLE_BITS];
  endfunction

  // cordic angle to 16 bit binary angle, rounded half up, wrapping
  function automatic logic [15:0] heading16(input logic [ANGLE_BITS-1:0] z);
    logic [ANGLE_BITS+16:0] sum;
    sum = {1'b0, z, 16'd0} + ((ANGLE_BITS+17)'(1) << (ANGLE_BITS - 1));
    return sum[ANGLE_BITS +: 16];
  endfunction

endpackage

FILE: hdl/yaw_rate_limited_heading_tracker.sv
// ----------------------------------------------------------------------------
// yaw_rate_limited_heading_tracker
// heading from velocity by cordic atan2, rate limited, with yaw rate output
// ----------------------------------------------------------------------------
//  channel   handshake                        payload
//  in        in_valid / in_ready              in_data   (opcode, vel_x, vel_y, seed_yaw)
//  out       out_valid / out_ready            out_data  (yaw, yaw_rate, rate_limited)
//  config    psel, penable, pwrite / pready   paddr, pwdata, prdata
//
//  a velocity step takes the back end through idle, CORDIC_STEPS cordic iterations,
//  diff, multiply and finish, the shared cordic unit doing one micro-rotation a cycle
//  a hold step (speed below threshold) skips the iterations, a seed goes straight to finish
//  a two-entry request queue lets the front keep accepting while the back works
//  the result register holds until taken; the back waits in its last stage
//  synchronous active-low reset loads register defaults and clears stored yaw
module yaw_rate_limited_heading_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  yrlht_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output yrlht_pkg::out_item_t                 out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [yrlht_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [yrlht_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [yrlht_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  yrlht_pkg::cfg_t    cfg_r;
  yrlht_pkg::q_stat_t q_stat;
  yrlht_pkg::work_t   push_item;
  yrlht_pkg::work_t   pop_item;
  logic               push;
  logic               pop;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_yaw_rate     <= yrlht_pkg::RST_MAX_YAW_RATE;
      cfg_r.max_step_change  <= yrlht_pkg::RST_MAX_STEP_CHANGE;
      cfg_r.steps_per_second <= yrlht_pkg::RST_STEPS_PER_SECOND;
      cfg_r.speed_threshold  <= yrlht_pkg::RST_SPEED_THRESHOLD;
    end else if (wr_en) begin
      case (reg_idx)
        yrlht_pkg::REG_MAX_YAW_RATE:     cfg_r.max_yaw_rate     <= pwdata[22:0];
        yrlht_pkg::REG_MAX_STEP_CHANGE:  cfg_r.max_step_change  <= pwdata[14:0];
        yrlht_pkg::REG_STEPS_PER_SECOND: cfg_r.steps_per_second <= pwdata[9:0];
        yrlht_pkg::REG_SPEED_THRESHOLD:  cfg_r.speed_threshold  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      yrlht_pkg::REG_MAX_YAW_RATE:     prdata = 32'(cfg_r.max_yaw_rate);
      yrlht_pkg::REG_MAX_STEP_CHANGE:  prdata = 32'(cfg_r.max_step_change);
      yrlht_pkg::REG_STEPS_PER_SECOND: prdata = 32'(cfg_r.steps_per_second);
      yrlht_pkg::REG_SPEED_THRESHOLD:  prdata = 32'(cfg_r.speed_threshold);
      default:                         prdata = '0;
    endcase
  end

  yrlht_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .speed_threshold (cfg_r.speed_threshold),
    .q_stat          (q_stat),
    .push            (push),
    .push_item       (push_item)
  );

  yrlht_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  yrlht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (pop_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/yrlht_front.sv
// ----------------------------------------------------------------------------
// yrlht_front
// accepts input requests and classifies them as seed, hold or cordic step
// ----------------------------------------------------------------------------
module yrlht_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  yrlht_pkg::in_item_t in_data,
  input  logic [15:0]         speed_threshold,
  input  yrlht_pkg::q_stat_t  q_stat,
  output logic                push,
  output yrlht_pkg::work_t    push_item
);

  logic [16:0] abs_x;
  logic [16:0] abs_y;
  logic [17:0] speed;
  logic        slow;

  always_comb begin
    abs_x = in_data.vel_x[15] ? (17'd0 - 17'(in_data.vel_x)) : 17'(in_data.vel_x);
    abs_y = in_data.vel_y[15] ? (17'd0 - 17'(in_data.vel_y)) : 17'(in_data.vel_y);
    speed = 18'(abs_x) + 18'(abs_y);
    slow  = speed < {2'b00, speed_threshold};
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.vel_x    = in_data.vel_x;
    push_item.vel_y    = in_data.vel_y;
    push_item.seed_yaw = in_data.seed_yaw;
    if (in_data.opcode == yrlht_pkg::OPC_SEED) begin
      push_item.kind = yrlht_pkg::KIND_SEED;
    end else if (slow) begin
      // too slow for a heading: keep the stored yaw
      push_item.kind = yrlht_pkg::KIND_HOLD;
    end else begin
      push_item.kind = yrlht_pkg::KIND_STEP;
    end
  end

endmodule

FILE: hdl/yrlht_queue.sv
// ----------------------------------------------------------------------------
// yrlht_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module yrlht_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  yrlht_pkg::work_t   push_item,
  input  logic               pop,
  output yrlht_pkg::work_t   pop_item,
  output yrlht_pkg::q_stat_t q_stat
);

  localparam int DEPTH = yrlht_pkg::QUEUE_DEPTH;
  localparam int PW    = yrlht_pkg::QPTR_W;
  localparam int CW    = yrlht_pkg::QCNT_W;

  yrlht_pkg::work_t entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign pop_item     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

FILE: hdl/yrlht_back.sv
// ----------------------------------------------------------------------------
// yrlht_back
// iterative cordic atan2, wrapped difference and clamp, rate and output
// ----------------------------------------------------------------------------
`include "yaw_rate_limited_heading_tracker_macros.svh"

module yrlht_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  yrlht_pkg::cfg_t      cfg,
  input  yrlht_pkg::work_t     q_item,
  input  yrlht_pkg::q_stat_t   q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output yrlht_pkg::out_item_t out_data
);

  localparam int XW  = yrlht_pkg::XY_W;
  localparam int AW  = yrlht_pkg::ANGLE_BITS;
  localparam int IW  = yrlht_pkg::ITER_W;
  localparam int PRW = yrlht_pkg::PROD_W;
  localparam logic [IW-1:0] ITER_LAST = IW'(yrlht_pkg::CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_DIFF,
    S_MUL,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [IW-1:0]         iter_r;
  logic signed [XW-1:0]  x_r;
  logic signed [XW-1:0]  y_r;
  logic [AW-1:0]         z_r;
  logic                  hold_r;
  logic [15:0]           stored_yaw_r;
  logic [15:0]           new_yaw_r;
  logic signed [15:0]    diff_r;
  logic                  limited_r;
  logic                  lim_neg_r;
  logic signed [PRW-1:0] prod_r;
  logic                  out_valid_r;
  yrlht_pkg::out_item_t  out_data_r;

  // cordic start vector
  logic signed [XW-1:0] vx0;
  logic signed [XW-1:0] vy0;
  logic signed [XW-1:0] x_init;
  logic signed [XW-1:0] y_init;
  logic [AW-1:0]        z_init;

  always_comb begin
    vx0 = XW'(q_item.vel_x) <<< yrlht_pkg::PRESCL;
    vy0 = XW'(q_item.vel_y) <<< yrlht_pkg::PRESCL;
    if (q_item.vel_x[15]) begin
      // left half plane: rotate by half a turn first
      x_init = -vx0;
      y_init = -vy0;
      z_init = AW'(1) << (AW - 1);
    end else begin
      x_init = vx0;
      y_init = vy0;
      z_init = '0;
    end
  end

  // one cordic micro-rotation
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic [AW-1:0]        ang;
  logic signed [XW-1:0] x_step;
  logic signed [XW-1:0] y_step;
  logic [AW-1:0]        z_step;

  always_comb begin
    dx  = y_r >>> iter_r;
    dy  = x_r >>> iter_r;
    ang = yrlht_pkg::atan_angle(5'(iter_r));
    if (!y_r[XW-1]) begin
      x_step = x_r + dx;
      y_step = y_r - dy;
      z_step = z_r + ang;
    end else begin
      x_step = x_r - dx;
      y_step = y_r + dy;
      z_step = z_r - ang;
    end
  end

  // wrapped difference and step clamp
  logic [15:0]        target;
  logic signed [15:0] diff_raw;
  logic signed [16:0] diff_ext;
  logic signed [16:0] lim_ext;
  logic               over_pos;
  logic               over_neg;
  logic signed [15:0] diff_clamped;

  always_comb begin
    target   = hold_r ? stored_yaw_r : yrlht_pkg::heading16(z_r);
    diff_raw = target - stored_yaw_r;
    diff_ext = 17'(diff_raw);
    lim_ext  = signed'({2'b00, cfg.max_step_change});
    over_pos = diff_ext > lim_ext;
    over_neg = diff_ext < -lim_ext;
    if (over_pos) begin
      diff_clamped = 16'(lim_ext);
    end else if (over_neg) begin
      diff_clamped = 16'(-lim_ext);
    end else begin
      diff_clamped = diff_raw;
    end
  end

  // final rate selection
  logic signed [23:0] lim_rate;
  logic signed [23:0] rate_fin;
  logic               fin_go;

  always_comb begin
    lim_rate = signed'({1'b0, cfg.max_yaw_rate});
    if (limited_r) begin
      rate_fin = lim_neg_r ? -lim_rate : lim_rate;
    end else if (prod_r > PRW'(yrlht_pkg::RATE_MAX)) begin
      rate_fin = yrlht_pkg::RATE_MAX;
    end else if (prod_r < PRW'(yrlht_pkg::RATE_MIN)) begin
      rate_fin = yrlht_pkg::RATE_MIN;
    end else begin
      rate_fin = 24'(prod_r);
    end
  end

  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stored_yaw_r <= '0;
      out_valid_r  <= 1'b0;
      iter_r       <= '0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            x_r       <= x_init;
            y_r       <= y_init;
            z_r       <= z_init;
            iter_r    <= '0;
            hold_r    <= (q_item.kind == yrlht_pkg::KIND_HOLD);
            limited_r <= 1'b0;
            lim_neg_r <= 1'b0;
            case (q_item.kind)
              yrlht_pkg::KIND_SEED: begin
                new_yaw_r <= q_item.seed_yaw;
                prod_r    <= '0;
                state_r   <= S_FIN;
              end
              yrlht_pkg::KIND_HOLD: begin
                state_r <= S_DIFF;
              end
              default: begin
                state_r <= S_ITER;
              end
            endcase
          end
        end
        S_ITER: begin
          x_r    <= x_step;
          y_r    <= y_step;
          z_r    <= z_step;
          iter_r <= iter_r + IW'(1);
          if (iter_r == ITER_LAST) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r    <= diff_clamped;
          new_yaw_r <= stored_yaw_r + diff_clamped;
          limited_r <= over_pos || over_neg;
          lim_neg_r <= over_neg;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PRW'(diff_r) * PRW'(signed'({1'b0, cfg.steps_per_second}));
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            stored_yaw_r            <= new_yaw_r;
            out_data_r.yaw          <= new_yaw_r;
            out_data_r.yaw_rate     <= rate_fin;
            out_data_r.rate_limited <= limited_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // terms for the checks below
  logic yaw_match;
  logic lim_out_ok;
  logic fin_done;

  assign yaw_match  = (out_data_r.yaw == stored_yaw_r);
  assign lim_out_ok = !out_data_r.rate_limited || (out_data_r.yaw_rate == lim_rate) ||
                      (out_data_r.yaw_rate == -lim_rate);
  assign fin_done   = (state_r == S_IDLE) && out_valid_r;

  `YRLHT_ASSERT_SAME(a_out_yaw_is_stored, out_valid_r, yaw_match, "result yaw not stored")
  `YRLHT_ASSERT_SAME(a_iter_bound, state_r == S_ITER, iter_r <= ITER_LAST, "iteration out of range")
  `YRLHT_ASSERT_SAME(a_limited_rate, out_valid_r, lim_out_ok, "clamped result without max rate")
  `YRLHT_ASSERT_NEXT(a_fin_delivers, fin_go, fin_done, "finished request not presented")

endmodule
